FILE: design/clap_pattern_detector_assert.svh
// Assertion macros for the clap pattern detector.
// Used by the top level only; relies on the clk and arst_n ports being in scope.
`ifndef CLAP_PATTERN_DETECTOR_ASSERT_SVH
`define CLAP_PATTERN_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clap pattern detector: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clap pattern detector: next-cycle check failed");

`endif

FILE: design/cpd_pkg.sv
// Shared types and constants of the clap pattern detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

	localparam int unsigned CFG_BITS       = 26;
	localparam int unsigned REQ_BITS       = 4;
	localparam int unsigned COUNT_BITS     = 4;
	localparam int unsigned OUTCOME_BITS   = 3;
	localparam int unsigned CFG_INDEX_BITS = 3;

	localparam int unsigned DEFAULT_MAX_CLAPS = 8;
	localparam int unsigned DEFAULT_TIME_BITS = 48;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_BITS-1:0] RESET_DEBOUNCE = CFG_BITS'(150 * 1000);
	localparam logic [CFG_BITS-1:0] RESET_MAX_GAP  = CFG_BITS'(1500 * 1000);
	localparam logic [CFG_BITS-1:0] RESET_WINDOW   = CFG_BITS'(4000 * 1000);
	localparam logic [CFG_BITS-1:0] RESET_LOCKOUT  = CFG_BITS'(3000 * 1000);
	localparam logic [REQ_BITS-1:0] RESET_REQUIRED = REQ_BITS'(3);

	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_GAP  = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW   = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOCKOUT  = CFG_INDEX_BITS'(3);
	localparam logic [CFG_INDEX_BITS-1:0] REG_REQUIRED = CFG_INDEX_BITS'(4);

	typedef enum logic [OUTCOME_BITS-1:0] {
		OUT_DROPPED  = 3'd0,
		OUT_COUNTED  = 3'd1,
		OUT_GAP      = 3'd2,
		OUT_WINDOW   = 3'd3,
		OUT_COMPLETE = 3'd4
	} cpd_outcome_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce;
		logic [CFG_BITS-1:0] max_gap;
		logic [CFG_BITS-1:0] window;
		logic [CFG_BITS-1:0] lockout;
		logic [REQ_BITS-1:0] required;
	} cpd_cfg_t;

endpackage

`default_nettype wire

FILE: design/cpd_front.sv
// Front end of the clap pattern detector: a short queue of event timestamps.
// Depends on cpd_pkg for the queue depth and the default timestamp width.
`timescale 1ns / 1ps
`default_nettype none

module cpd_front #(
	parameter int unsigned TIME_BITS = cpd_pkg::DEFAULT_TIME_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic [TIME_BITS-1:0] event_time,
	output logic                      full,
	output logic                      head_valid,
	output logic [TIME_BITS-1:0]      head_time,
	input  wire logic                 take
);

	localparam int unsigned PTR_W = (cpd_pkg::QUEUE_DEPTH > 1) ? $clog2(cpd_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(cpd_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cpd_pkg::QUEUE_DEPTH - 1);

	logic [TIME_BITS-1:0] mem_q [cpd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_take;

	assign full       = (count_q == CNT_W'(cpd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_time  = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_take    = take & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= event_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_take) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_take})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/cpd_back.sv
// Back end of the clap pattern detector: debounce, gap and window tests,
// clap counting and the switch state, followed by a short result queue.
// Depends on cpd_pkg for the configuration struct, outcome codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module cpd_back #(
	parameter int unsigned MAX_CLAPS = cpd_pkg::DEFAULT_MAX_CLAPS,
	parameter int unsigned TIME_BITS = cpd_pkg::DEFAULT_TIME_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic [TIME_BITS-1:0]              in_time,
	output logic                                   in_take,
	input  wire cpd_pkg::cpd_cfg_t                 cfg,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [cpd_pkg::OUTCOME_BITS-1:0]       outcome,
	output logic [cpd_pkg::COUNT_BITS-1:0]         clap_tally,
	output logic                                   switch_on
);

	localparam int unsigned CW    = cpd_pkg::COUNT_BITS;
	localparam int unsigned PTR_W = (cpd_pkg::QUEUE_DEPTH > 1) ? $clog2(cpd_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(cpd_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cpd_pkg::QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]    MAX_NEED = CW'(MAX_CLAPS);

	typedef struct packed {
		cpd_pkg::cpd_outcome_t outcome;
		logic [CW-1:0]         count;
		logic                  on;
	} result_t;

	logic [TIME_BITS-1:0] ref_q;
	logic [TIME_BITS-1:0] first_q;
	logic [TIME_BITS-1:0] prev_q;
	logic [CW-1:0]        count_q;
	logic                 on_q;

	logic [TIME_BITS-1:0] d_ref;
	logic [TIME_BITS-1:0] d_prev;
	logic [TIME_BITS-1:0] d_first;
	logic [CW-1:0]        need;
	logic                 pass;
	logic                 gap_hit;
	logic                 win_hit;
	logic [CW-1:0]        base_cnt;
	logic [CW-1:0]        new_cnt;
	logic                 complete;
	result_t              res;

	result_t              rq_mem_q [cpd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]     rq_wr_q;
	logic [PTR_W-1:0]     rq_rd_q;
	logic [CNT_W-1:0]     rq_cnt_q;
	logic                 rq_full;
	logic                 do_pop;

	assign rq_full = (rq_cnt_q == CNT_W'(cpd_pkg::QUEUE_DEPTH));
	assign empty   = (rq_cnt_q == '0);
	assign do_pop  = pop & ~empty;
	assign in_take = in_valid & ~rq_full;

	always_comb begin
		d_ref   = in_time - ref_q;
		d_prev  = in_time - prev_q;
		d_first = in_time - first_q;

		if (cfg.required == '0) begin
			need = CW'(1);
		end else if (cfg.required > MAX_NEED) begin
			need = MAX_NEED;
		end else begin
			need = cfg.required;
		end

		pass    = ~d_ref[TIME_BITS-1] && (d_ref >= TIME_BITS'(cfg.debounce));
		gap_hit = (count_q != '0) && ~d_prev[TIME_BITS-1] &&
			(d_prev > TIME_BITS'(cfg.max_gap));
		win_hit = (count_q != '0) && ~gap_hit && ~d_first[TIME_BITS-1] &&
			(d_first > TIME_BITS'(cfg.window));

		base_cnt = (gap_hit || win_hit) ? '0 : count_q;
		new_cnt  = base_cnt + CW'(1);
		complete = (new_cnt >= need);

		if (!pass) begin
			res.outcome = cpd_pkg::OUT_DROPPED;
			res.count   = count_q;
			res.on      = on_q;
		end else begin
			if (complete) begin
				res.outcome = cpd_pkg::OUT_COMPLETE;
			end else if (win_hit) begin
				res.outcome = cpd_pkg::OUT_WINDOW;
			end else if (gap_hit) begin
				res.outcome = cpd_pkg::OUT_GAP;
			end else begin
				res.outcome = cpd_pkg::OUT_COUNTED;
			end
			res.count = complete ? '0 : new_cnt;
			res.on    = on_q ^ complete;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= '0;
			first_q <= '0;
			prev_q  <= '0;
			count_q <= '0;
			on_q    <= 1'b0;
		end else if (in_take && pass) begin
			ref_q   <= complete ? in_time + TIME_BITS'(cfg.lockout) : in_time;
			if (base_cnt == '0) begin
				first_q <= in_time;
			end
			prev_q  <= in_time;
			count_q <= res.count;
			on_q    <= res.on;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rq_mem_q[rq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (in_take) begin
				rq_wr_q <= (rq_wr_q == LAST_PTR) ? '0 : rq_wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rq_rd_q <= (rq_rd_q == LAST_PTR) ? '0 : rq_rd_q + PTR_W'(1);
			end
			case ({in_take, do_pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + CNT_W'(1);
				2'b01:   rq_cnt_q <= rq_cnt_q - CNT_W'(1);
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	assign outcome    = rq_mem_q[rq_rd_q].outcome;
	assign clap_tally = rq_mem_q[rq_rd_q].count;
	assign switch_on  = rq_mem_q[rq_rd_q].on;

endmodule

`default_nettype wire

FILE: design/clap_pattern_detector.sv
// Top level of the clap pattern detector: configuration registers, front queue and back end.
// Depends on cpd_pkg, cpd_front, cpd_back and clap_pattern_detector_assert.svh.
//
// Events arrive as microsecond timestamps through a queue-style port: an item is taken on a
// rising edge with push high and full low. Results leave through a queue-style port: while
// empty is low the oldest result is on outcome, clap_tally and switch_on, and it is removed
// on a rising edge with pop high. Every event gives exactly one result.
// An event item is registered in the event queue; the back end takes it from the head and
// writes its result into the result queue. Throughput is one event per cycle while results
// are popped, set by the combinational evaluation in the back end against its registered
// clap state. A two-entry queue on each side decouples the ports, so a consumer that holds
// pop low first fills the result queue and then the event queue, after which full rises; no
// item is lost. No event is taken while the result queue is full.
// Configuration registers are written through cfg_wr_en, cfg_addr and cfg_wdata and should
// only change while no events are in flight. Unknown addresses are ignored.
// Asynchronous reset clears both queues, the clap state and the switch, and restores the
// configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "clap_pattern_detector_assert.svh"

module clap_pattern_detector #(
	parameter int unsigned MAX_CLAPS = cpd_pkg::DEFAULT_MAX_CLAPS,
	parameter int unsigned TIME_BITS = cpd_pkg::DEFAULT_TIME_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [TIME_BITS-1:0]                event_time,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [cpd_pkg::OUTCOME_BITS-1:0]         outcome,
	output logic [cpd_pkg::COUNT_BITS-1:0]           clap_tally,
	output logic                                     switch_on,
	input  wire logic                                cfg_wr_en,
	input  wire logic [cpd_pkg::CFG_INDEX_BITS-1:0]  cfg_addr,
	input  wire logic [cpd_pkg::CFG_BITS-1:0]        cfg_wdata
);

	cpd_pkg::cpd_cfg_t    cfg_q;
	logic                 head_valid;
	logic [TIME_BITS-1:0] head_time;
	logic                 head_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce <= cpd_pkg::RESET_DEBOUNCE;
			cfg_q.max_gap  <= cpd_pkg::RESET_MAX_GAP;
			cfg_q.window   <= cpd_pkg::RESET_WINDOW;
			cfg_q.lockout  <= cpd_pkg::RESET_LOCKOUT;
			cfg_q.required <= cpd_pkg::RESET_REQUIRED;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				cpd_pkg::REG_DEBOUNCE: cfg_q.debounce <= cfg_wdata;
				cpd_pkg::REG_MAX_GAP:  cfg_q.max_gap  <= cfg_wdata;
				cpd_pkg::REG_WINDOW:   cfg_q.window   <= cfg_wdata;
				cpd_pkg::REG_LOCKOUT:  cfg_q.lockout  <= cfg_wdata;
				cpd_pkg::REG_REQUIRED: cfg_q.required <= cfg_wdata[cpd_pkg::REQ_BITS-1:0];
				default:               cfg_q          <= cfg_q;
			endcase
		end
	end

	cpd_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.event_time (event_time),
		.full       (full),
		.head_valid (head_valid),
		.head_time  (head_time),
		.take       (head_take)
	);

	cpd_back #(
		.MAX_CLAPS (MAX_CLAPS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (head_valid),
		.in_time    (head_time),
		.in_take    (head_take),
		.cfg        (cfg_q),
		.empty      (empty),
		.pop        (pop),
		.outcome    (outcome),
		.clap_tally (clap_tally),
		.switch_on  (switch_on)
	);

	`CPD_ASSERT_NOW(a_complete_clears_count,
		!empty && outcome == cpd_pkg::OUT_COMPLETE, clap_tally == '0)
	`CPD_ASSERT_NOW(a_restart_counts_one,
		!empty && (outcome == cpd_pkg::OUT_GAP || outcome == cpd_pkg::OUT_WINDOW),
		clap_tally == cpd_pkg::COUNT_BITS'(1))
	`CPD_ASSERT_NEXT(a_full_holds_without_take,
		full && !head_take, full)

endmodule

`default_nettype wire

FILE: test/clap_pattern_detector_checker.sv
// Checker for the clap pattern detector: watches the event, result and register ports.
// Predicts the result of every accepted event item and compares it with what the block returns.
// Depends on cpd_pkg.
`timescale 1ns / 1ps

module clap_pattern_detector_checker #(
	parameter int unsigned MAX_CLAPS = cpd_pkg::DEFAULT_MAX_CLAPS,
	parameter int unsigned TIME_BITS = cpd_pkg::DEFAULT_TIME_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire logic                               full,
	input  wire logic [TIME_BITS-1:0]               event_time,
	input  wire logic                               empty,
	input  wire logic                               pop,
	input  wire logic [cpd_pkg::OUTCOME_BITS-1:0]   outcome,
	input  wire logic [cpd_pkg::COUNT_BITS-1:0]     clap_tally,
	input  wire logic                               switch_on,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cpd_pkg::CFG_INDEX_BITS-1:0] cfg_addr,
	input  wire logic [cpd_pkg::CFG_BITS-1:0]       cfg_wdata,
	output int unsigned                             failures,
	output int unsigned                             awaiting
);

	typedef struct packed {
		cpd_pkg::cpd_outcome_t          outcome;
		logic [cpd_pkg::COUNT_BITS-1:0] claps;
		logic                           lamp;
	} clap_result_t;

	cpd_pkg::cpd_cfg_t              regs;
	logic [TIME_BITS-1:0]           ref_time;
	logic [TIME_BITS-1:0]           first_time;
	logic [TIME_BITS-1:0]           prev_time;
	logic [cpd_pkg::COUNT_BITS-1:0] claps_held;
	logic                           lamp_on;
	clap_result_t                   expected_results [$];
	int unsigned                    results_seen;

	function automatic clap_result_t judge_event(input logic [TIME_BITS-1:0] stamp);
		clap_result_t         res;
		logic [TIME_BITS-1:0] since_ref;
		logic [TIME_BITS-1:0] since_prev;
		logic [TIME_BITS-1:0] since_first;
		int unsigned          need;
		need = 32'(regs.required);
		if (need < 1) need = 1;
		if (need > MAX_CLAPS) need = MAX_CLAPS;
		res.outcome = cpd_pkg::OUT_DROPPED;
		since_ref = stamp - ref_time;
		// The top bit of a wrapped difference marks it as negative.
		if (!since_ref[TIME_BITS-1] && since_ref >= TIME_BITS'(regs.debounce)) begin
			ref_time = stamp;
			res.outcome = cpd_pkg::OUT_COUNTED;
			since_prev = stamp - prev_time;
			since_first = stamp - first_time;
			if (claps_held != 0 && !since_prev[TIME_BITS-1] &&
					since_prev > TIME_BITS'(regs.max_gap)) begin
				claps_held = '0;
				res.outcome = cpd_pkg::OUT_GAP;
			end
			if (claps_held != 0 && !since_first[TIME_BITS-1] &&
					since_first > TIME_BITS'(regs.window)) begin
				claps_held = '0;
				res.outcome = cpd_pkg::OUT_WINDOW;
			end
			if (claps_held == 0) first_time = stamp;
			prev_time = stamp;
			claps_held = claps_held + cpd_pkg::COUNT_BITS'(1);
			if (claps_held >= need) begin
				claps_held = '0;
				lamp_on = ~lamp_on;
				ref_time = stamp + TIME_BITS'(regs.lockout);
				res.outcome = cpd_pkg::OUT_COMPLETE;
			end
		end
		res.claps = claps_held;
		res.lamp = lamp_on;
		return res;
	endfunction

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		clap_result_t want;
		if (!arst_n) begin
			regs = {cpd_pkg::RESET_DEBOUNCE, cpd_pkg::RESET_MAX_GAP, cpd_pkg::RESET_WINDOW,
				cpd_pkg::RESET_LOCKOUT, cpd_pkg::RESET_REQUIRED};
			ref_time = '0;
			first_time = '0;
			prev_time = '0;
			claps_held = '0;
			lamp_on = 1'b0;
			expected_results.delete();
			results_seen = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					cpd_pkg::REG_DEBOUNCE: regs.debounce = cfg_wdata;
					cpd_pkg::REG_MAX_GAP:  regs.max_gap = cfg_wdata;
					cpd_pkg::REG_WINDOW:   regs.window = cfg_wdata;
					cpd_pkg::REG_LOCKOUT:  regs.lockout = cfg_wdata;
					cpd_pkg::REG_REQUIRED: regs.required = cfg_wdata[cpd_pkg::REQ_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (pop && !empty) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					log_failure($sformatf("result %0d arrived with no event item waiting",
						results_seen));
				end else begin
					want = expected_results.pop_front();
					if (outcome !== want.outcome || clap_tally !== want.claps ||
							switch_on !== want.lamp) begin
						log_failure($sformatf({"result %0d: expected outcome %0d count %0d ",
							"switch %0b, got outcome %0d count %0d switch %0b"},
							results_seen, want.outcome, want.claps, want.lamp,
							outcome, clap_tally, switch_on));
					end
				end
			end
			if (push && !full) expected_results.push_back(judge_event(event_time));
		end
		awaiting = expected_results.size();
	end

endmodule

FILE: test/clap_pattern_detector_tb.sv
// Top of the clap pattern detector testbench: clock, reset, event and register stimulus, verdict.
// Depends on cpd_pkg, clap_pattern_detector and clap_pattern_detector_checker.
`timescale 1ns / 1ps

module clap_pattern_detector_tb;

	localparam int unsigned STAMP_BITS = cpd_pkg::DEFAULT_TIME_BITS;
	localparam int unsigned CFG_BITS = cpd_pkg::CFG_BITS;
	localparam int unsigned REQ_BITS = cpd_pkg::REQ_BITS;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 165;
	localparam int unsigned PRESSURE_CYCLES = 300;
	localparam int PRESSURE_PHASE = 0;
	localparam logic [cpd_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = cpd_pkg::CFG_INDEX_BITS'(7);
	localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   push = 1'b0;
	logic [STAMP_BITS-1:0]                  event_time = '0;
	logic                                   pop = 1'b0;
	logic                                   cfg_wr_en = 1'b0;
	logic [cpd_pkg::CFG_INDEX_BITS-1:0]     cfg_addr = '0;
	logic [CFG_BITS-1:0]                    cfg_wdata = '0;
	wire logic                              full;
	wire logic                              empty;
	wire logic [cpd_pkg::OUTCOME_BITS-1:0]  outcome;
	wire logic [cpd_pkg::COUNT_BITS-1:0]    clap_tally;
	wire logic                              switch_on;
	int unsigned                            failures;
	int unsigned                            awaiting;
	int unsigned                            cycle_count = 0;

	idle_mode_t            idle_mode = IDLE_NONE;
	int                    phase_no = -1;
	cpd_pkg::cpd_cfg_t     settings;
	logic [STAMP_BITS-1:0] now_us;

	clap_pattern_detector dut (.*);

	clap_pattern_detector_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sender_gap_pct(input idle_mode_t m);
		return (m == IDLE_SENDER) ? 83 : (m == IDLE_BOTH) ? 14 : 0;
	endfunction

	function automatic int unsigned receiver_stall_pct(input idle_mode_t m);
		return (m == IDLE_RECEIVER) ? 83 : (m == IDLE_BOTH) ? 14 : 0;
	endfunction

	function automatic cpd_pkg::cpd_cfg_t phase_settings(input int p);
		case (p)
			0: return {CFG_BITS'(50), CFG_BITS'(400), CFG_BITS'(1000), CFG_BITS'(600), REQ_BITS'(3)};
			1: return {CFG_BITS'(0), CFG_BITS'(100), CFG_BITS'(250), CFG_BITS'(0), REQ_BITS'(1)};
			2: return {CFG_BITS'(20), CFG_BITS'(300), CFG_BITS'(500), CFG_BITS'(200), REQ_BITS'(8)};
			3: return {CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, REQ_BITS'(2)};
			4: return {CFG_BITS'(0), CFG_BITS'(0), CFG_BITS'(0), CFG_BITS'(0), REQ_BITS'(0)};
			5: return {CFG_BITS'(100), CFG_BITS'(1000), CFG_BITS'(2000), CFG_BITS'(5000), REQ_BITS'(15)};
			6: return {CFG_BITS'(30), CFG_BITS'(200), CFG_BITS'(350), CFG_BITS'(100), REQ_BITS'(4)};
			default: return {CFG_BITS'(1), CFG_MAX, CFG_BITS'(300), CFG_BITS'(50), REQ_BITS'(5)};
		endcase
	endfunction

	// Mostly clap-like spacing, with drops, gaps, lockout edges, backward steps and wide jumps.
	function automatic logic [STAMP_BITS-1:0] next_stamp(input logic [STAMP_BITS-1:0] now,
			input cpd_pkg::cpd_cfg_t s);
		int unsigned           pick;
		int unsigned           deb;
		int unsigned           gap;
		int unsigned           win;
		int unsigned           lock;
		logic [STAMP_BITS-1:0] step;
		pick = $urandom_range(0, 99);
		deb = 32'(s.debounce);
		gap = 32'(s.max_gap);
		win = 32'(s.window);
		lock = 32'(s.lockout);
		if (pick < 55) step = STAMP_BITS'($urandom_range(deb, gap));
		else if (pick < 65) step = STAMP_BITS'($urandom_range(0, (deb == 0) ? 0 : deb - 1));
		else if (pick < 75) step = STAMP_BITS'($urandom_range(gap + 1, gap + deb + 64));
		else if (pick < 83) step = STAMP_BITS'($urandom_range(0, win + lock));
		else if (pick < 90) step = STAMP_BITS'($urandom_range(lock, lock + deb + 16));
		else if (pick < 96) return now - STAMP_BITS'($urandom_range(0, deb + lock + 64));
		else step = STAMP_BITS'({$urandom_range(0, 32'h7FFF), $urandom});
		return now + step;
	endfunction

	task automatic send_event(input logic [STAMP_BITS-1:0] stamp);
		while ($urandom_range(0, 99) < sender_gap_pct(idle_mode)) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		event_time <= stamp;
		do @(posedge clk); while (full !== 1'b0);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [cpd_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_BITS-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input cpd_pkg::cpd_cfg_t s);
		settings = s;
		write_reg(REG_UNUSED, CFG_BITS'($urandom));
		write_reg(cpd_pkg::REG_DEBOUNCE, s.debounce);
		write_reg(cpd_pkg::REG_MAX_GAP, s.max_gap);
		write_reg(cpd_pkg::REG_WINDOW, s.window);
		write_reg(cpd_pkg::REG_LOCKOUT, s.lockout);
		write_reg(cpd_pkg::REG_REQUIRED, CFG_BITS'(s.required));
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [STAMP_BITS-1:0] opening [17];
		logic [STAMP_BITS-1:0] base;
		opening = '{48'd0, 48'd149999, 48'd150000, 48'd300000, 48'd450000, 48'd1000000,
			48'd3449999, 48'd3450000, 48'd4950001, 48'd5950001, 48'd6950001, 48'd100,
			48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hBFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'h0000_0010_0000};
		settings = {cpd_pkg::RESET_DEBOUNCE, cpd_pkg::RESET_MAX_GAP, cpd_pkg::RESET_WINDOW,
			cpd_pkg::RESET_LOCKOUT, cpd_pkg::RESET_REQUIRED};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_event(opening[i]);
		drain();

		base = 48'h0000_1000_0000_0000;
		apply_settings({CFG_BITS'(0), CFG_BITS'(10), CFG_BITS'(25), CFG_BITS'(0), REQ_BITS'(15)});
		send_event(base);
		send_event(base + 10);
		send_event(base + 20);
		send_event(base + 30);
		send_event(base + 41);
		send_event(base + 41);
		drain();

		// A restarting clap that completes the pattern on its own, then the longest lockout.
		base = base + 1000;
		apply_settings({CFG_BITS'(0), CFG_BITS'(10), CFG_BITS'(25), CFG_MAX, REQ_BITS'(3)});
		send_event(base);
		send_event(base + 5);
		drain();
		apply_settings({CFG_BITS'(0), CFG_BITS'(10), CFG_BITS'(25), CFG_MAX, REQ_BITS'(0)});
		send_event(base + 1000);
		send_event(base + 1001);
		drain();

		now_us = base + 1001;
		for (int p = 0; p < PHASES; p++) begin
			apply_settings(phase_settings(p));
			idle_mode = idle_mode_t'(p % 4);
			phase_no = p;
			now_us = now_us + 48'h1000_0000;
			repeat (ITEMS_PER_PHASE) begin
				now_us = next_stamp(now_us, settings);
				send_event(now_us);
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (failures == 0 && awaiting == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// The receiver holds off once for a long stretch so that both queues fill and full rises.
	initial begin
		int unsigned held;
		bit          pressure_done;
		held = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!pressure_done && phase_no == PRESSURE_PHASE) begin
				pressure_done = 1'b1;
				held = PRESSURE_CYCLES;
			end
			if (held != 0) begin
				held--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= receiver_stall_pct(idle_mode));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
